// ===== hdl/egr_pkg.sv =====
// shared types, constants and the exponent root table for the gain rider
`default_nettype none
package egr_pkg;

	typedef struct packed {
		logic [24:0]        att_coeff;
		logic [24:0]        rel_coeff;
		logic signed [14:0] target_db;
		logic [16:0]        sens;
		logic [12:0]        range_db;
	} cfg_t;

	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_RELEASE = 3'd1;
	localparam logic [2:0] REG_TARGET  = 3'd2;
	localparam logic [2:0] REG_SENS    = 3'd3;
	localparam logic [2:0] REG_RANGE   = 3'd4;

	localparam logic [24:0] COEFF_ONE   = 25'd16777216;
	localparam logic [23:0] GAIN_MAX    = 24'd16777215;
	localparam logic [23:0] GAIN_ONE    = 24'd1048576;
	localparam logic [39:0] ENV_FLOOR   = 40'd54975581;
	localparam logic [31:0] DB_PER_OCT  = 32'd394566;
	localparam logic [31:0] OCT_PER_DB  = 32'd2786635;
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;

	localparam logic [24:0] ATT_RST    = 25'd6990;
	localparam logic [24:0] REL_RST    = 25'd3495;
	localparam logic [14:0] TARGET_RST = 15'h6E00;
	localparam logic [16:0] SENS_RST   = 17'd49152;
	localparam logic [12:0] RANGE_RST  = 13'd3072;

	typedef logic [30:0] root_tab_t [16];

	// floor integer square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// chain of square roots of 2.0 in q1.30, entry k is 2^(1/2^(k+1))
	function automatic root_tab_t root_tab();
		root_tab_t   t;
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int k = 0; k < 16; k++) begin
			r = isqrt_c(r << 30);
			t[k] = r[30:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = root_tab();

endpackage
`default_nettype wire

// ===== hdl/envelope_gain_rider_top.sv =====
// top level of the envelope gain rider: stream ports, config registers, output register
// sequencing: all products go through the one shared multiplier, 16 squarings for the log
// and 16 root products for the exponent; the normalisation shifts 0 to 14 times
// input is refused while the sequencer runs; a result waits while the output register is full
// reset: arst_n clears state at once, envelope to zero, gain to 1.0, registers to defaults
`default_nettype none
module envelope_gain_rider_top #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// input stream
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // sample_in
	// result stream
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [((SAMPLE_BITS+24+7)/8)*8-1:0]          m_tdata,   // sample_out, gain_now
	// configuration writes
	input  wire logic                                    cfg_we,
	input  wire logic [2:0]                              cfg_addr,
	input  wire logic [24:0]                             cfg_wdata
);
	import egr_pkg::*;

	localparam int OUT_W = ((SAMPLE_BITS + 24 + 7) / 8) * 8;

	cfg_t cfg_q;

	// register writes, coefficients limited to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.att_coeff <= ATT_RST;
			cfg_q.rel_coeff <= REL_RST;
			cfg_q.target_db <= TARGET_RST;
			cfg_q.sens      <= SENS_RST;
			cfg_q.range_db  <= RANGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ATTACK:  cfg_q.att_coeff <= (cfg_wdata > COEFF_ONE) ? COEFF_ONE : cfg_wdata;
				REG_RELEASE: cfg_q.rel_coeff <= (cfg_wdata > COEFF_ONE) ? COEFF_ONE : cfg_wdata;
				REG_TARGET:  cfg_q.target_db <= cfg_wdata[14:0];
				REG_SENS:    cfg_q.sens      <= cfg_wdata[16:0];
				REG_RANGE:   cfg_q.range_db  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	logic                   busy;
	logic                   done;
	logic                   out_free;
	logic                   start;
	logic [SAMPLE_BITS-1:0] res_sample;
	logic [23:0]            res_gain;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;

	// the output register lets a new item in while the last result waits
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !busy;
	assign start    = s_tvalid && s_tready;

	egr_core #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.cfg        (cfg_q),
		.out_free   (out_free),
		.busy       (busy),
		.done       (done),
		.res_sample (res_sample),
		.res_gain   (res_gain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, gain above the sample
	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= OUT_W'({res_gain, res_sample});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid)
		else $error("finished result not presented");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result without an item in progress");

endmodule
`default_nettype wire

// ===== hdl/egr_mul.sv =====
// shared unsigned 32x32 multiplier with registered product
`default_nettype none
module egr_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

// ===== hdl/egr_core.sv =====
// sequencer and datapath around the shared multiplier
`default_nettype none
module egr_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire egr_pkg::cfg_t          cfg,
	input  wire logic                   out_free,
	output logic                        busy,
	output logic                        done,
	output logic [SAMPLE_BITS-1:0]      res_sample,
	output logic [23:0]                 res_gain
);
	import egr_pkg::*;

	localparam int LVL_SHIFT = 40 - SAMPLE_BITS;
	localparam logic [36:0] HALF = 37'(1) << (SAMPLE_BITS - 1);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_ENV_LO  = 5'd1;
	localparam logic [4:0] S_ENV_HI  = 5'd2;
	localparam logic [4:0] S_ENV_UPD = 5'd3;
	localparam logic [4:0] S_FLOOR   = 5'd4;
	localparam logic [4:0] S_NORM    = 5'd5;
	localparam logic [4:0] S_SQ      = 5'd6;
	localparam logic [4:0] S_SQ_R    = 5'd7;
	localparam logic [4:0] S_DB      = 5'd8;
	localparam logic [4:0] S_DB_R    = 5'd9;
	localparam logic [4:0] S_SENS    = 5'd10;
	localparam logic [4:0] S_SENS_R  = 5'd11;
	localparam logic [4:0] S_EXP     = 5'd12;
	localparam logic [4:0] S_EXP_R   = 5'd13;
	localparam logic [4:0] S_ROOT    = 5'd14;
	localparam logic [4:0] S_ROOT_R  = 5'd15;
	localparam logic [4:0] S_GAIN    = 5'd16;
	localparam logic [4:0] S_GSM     = 5'd17;
	localparam logic [4:0] S_GSM_R   = 5'd18;
	localparam logic [4:0] S_OUT     = 5'd19;
	localparam logic [4:0] S_OUT_R   = 5'd20;

	logic [4:0]             state_q;
	logic [39:0]            env_q;
	logic [23:0]            gain_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic [39:0]            diff_q;
	logic                   up_q;
	logic [24:0]            coef_q;
	logic [44:0]            acc_q;
	logic [39:0]            norm_q;
	logic [5:0]             cnt_q;
	logic [30:0]            m_q;
	logic [15:0]            frac_q;
	logic [3:0]             k_q;
	logic [17:0]            dm_q;
	logic                   dneg_q;
	logic [12:0]            sm_q;
	logic [15:0]            ef_q;
	logic [4:0]             n_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] p;

	egr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ENV_LO: begin
				mul_a = 32'(coef_q);
				mul_b = 32'(diff_q[19:0]);
			end
			S_ENV_HI: begin
				mul_a = 32'(coef_q);
				mul_b = 32'(diff_q[39:20]);
			end
			S_SQ: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			S_DB: begin
				mul_a = 32'({cnt_q, 16'd0} - {6'd0, frac_q});
				mul_b = DB_PER_OCT;
			end
			S_SENS: begin
				mul_a = 32'(dm_q);
				mul_b = 32'(cfg.sens);
			end
			S_EXP: begin
				mul_a = 32'(sm_q);
				mul_b = OCT_PER_DB;
			end
			S_ROOT: begin
				mul_a = 32'(m_q);
				mul_b = ef_q[4'd15 - k_q] ? 32'(ROOTS[k_q]) : 32'(Q30_ONE);
			end
			S_GSM: begin
				mul_a = 32'(cfg.att_coeff);
				mul_b = 32'(diff_q[23:0]);
			end
			S_OUT, S_OUT_R: begin
				mul_a = 32'(mag_q);
				mul_b = 32'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// per-state datapath values
	logic [SAMPLE_BITS-1:0] in_mag;
	logic [39:0]            lvl;
	logic [63:0]            env_sum;
	logic [39:0]            env_step;
	logic [31:0]            sq_t;
	logic [47:0]            db_sum;
	logic [15:0]            dbm;
	logic signed [17:0]     d_w;
	logic [18:0]            smv;
	logic [35:0]            e_sum;
	logic [19:0]            em;
	logic [20:0]            e_w;
	logic signed [5:0]      s_w;
	logic [30:0]            g_sh;
	logic [23:0]            tg;
	logic [63:0]            o_sum;
	logic [36:0]            prod;

	always_comb begin
		in_mag   = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : sample;
		lvl      = 40'(in_mag) << LVL_SHIFT;
		env_sum  = {p[43:0], 20'd0} + 64'(acc_q);
		env_step = env_sum[63:24];
		sq_t     = p[61:30];
		db_sum   = p[47:0] + 48'(1 << 23);
		dbm      = db_sum[39:24];
		d_w      = 18'(cfg.target_db) + $signed({2'b00, dbm});
		smv      = p[34:16];
		e_sum    = p[35:0] + 36'd32768;
		em       = e_sum[35:16];
		e_w      = dneg_q ? 21'(-{1'b0, em}) : {1'b0, em};
		s_w      = 6'sd10 - $signed({n_q[4], n_q});
		g_sh     = m_q >> s_w[4:0];
		if (s_w < 0) begin
			tg = GAIN_MAX;
		end else if (g_sh > 31'(GAIN_MAX)) begin
			tg = GAIN_MAX;
		end else begin
			tg = g_sh[23:0];
		end
		o_sum = p + 64'(1 << 19);
		prod  = o_sum[56:20];
		if (neg_q) begin
			res_sample = SAMPLE_BITS'(-((prod > HALF) ? HALF : prod));
		end else begin
			res_sample = SAMPLE_BITS'((prod > HALF - 37'd1) ? HALF - 37'd1 : prod);
		end
	end

	assign res_gain = gain_q;
	assign busy     = state_q != S_IDLE;
	assign done     = state_q == S_OUT_R && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			env_q   <= '0;
			gain_q  <= GAIN_ONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mag_q  <= in_mag;
						neg_q  <= sample[SAMPLE_BITS-1];
						up_q   <= lvl > env_q;
						diff_q <= (lvl > env_q) ? lvl - env_q : env_q - lvl;
						coef_q <= (lvl > env_q) ? cfg.att_coeff : cfg.rel_coeff;
						state_q <= S_ENV_LO;
					end
				end
				S_ENV_LO: state_q <= S_ENV_HI;
				S_ENV_HI: begin
					acc_q   <= p[44:0];
					state_q <= S_ENV_UPD;
				end
				S_ENV_UPD: begin
					env_q   <= up_q ? env_q + env_step : env_q - env_step;
					state_q <= S_FLOOR;
				end
				S_FLOOR: begin
					norm_q  <= (env_q < ENV_FLOOR) ? ENV_FLOOR : env_q;
					cnt_q   <= '0;
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (norm_q[39]) begin
						m_q     <= norm_q[39:9];
						frac_q  <= '0;
						k_q     <= '0;
						state_q <= S_SQ;
					end else begin
						norm_q <= norm_q << 1;
						cnt_q  <= cnt_q + 6'd1;
					end
				end
				S_SQ: state_q <= S_SQ_R;
				S_SQ_R: begin
					frac_q  <= {frac_q[14:0], sq_t[31]};
					m_q     <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
					k_q     <= k_q + 4'd1;
					state_q <= (k_q == 4'd15) ? S_DB : S_SQ;
				end
				S_DB: state_q <= S_DB_R;
				S_DB_R: begin
					dneg_q  <= d_w < 0;
					dm_q    <= (d_w < 0) ? 18'(-d_w) : 18'(d_w);
					state_q <= S_SENS;
				end
				S_SENS: state_q <= S_SENS_R;
				S_SENS_R: begin
					sm_q    <= (smv > 19'(cfg.range_db)) ? cfg.range_db : smv[12:0];
					state_q <= S_EXP;
				end
				S_EXP: state_q <= S_EXP_R;
				S_EXP_R: begin
					n_q     <= e_w[20:16];
					ef_q    <= e_w[15:0];
					m_q     <= Q30_ONE;
					k_q     <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: state_q <= S_ROOT_R;
				S_ROOT_R: begin
					m_q     <= p[60:30];
					k_q     <= k_q + 4'd1;
					state_q <= (k_q == 4'd15) ? S_GAIN : S_ROOT;
				end
				S_GAIN: begin
					up_q    <= tg > gain_q;
					diff_q  <= 40'((tg > gain_q) ? tg - gain_q : gain_q - tg);
					state_q <= S_GSM;
				end
				S_GSM: state_q <= S_GSM_R;
				S_GSM_R: begin
					gain_q  <= up_q ? gain_q + p[47:24] : gain_q - p[47:24];
					state_q <= S_OUT;
				end
				S_OUT: state_q <= S_OUT_R;
				S_OUT_R: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_ENV_LO)
		else $error("item start did not enter the envelope step");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result finished while output register full");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NORM |-> cnt_q <= 6'd15)
		else $error("normalisation ran past the envelope floor");

endmodule
`default_nettype wire

// ===== sim/tb_envelope_gain_rider_top.sv =====
// self-checking testbench for the envelope gain rider: predictor, scoreboard and stream drivers
`default_nettype none
module tb_envelope_gain_rider_top;
	timeunit 1ns;
	timeprecision 1ps;
	import egr_pkg::*;

	localparam int SB = 24;

	// predicted transfer on the result stream
	typedef struct {
		logic [23:0] sample;
		logic [23:0] gain;
	} agc_result_t;

	// gain rider predictor: its own state, its own registers, and a queue of expected results
	class agc_scoreboard;
		logic [24:0]        att, rel;
		logic signed [14:0] tgt;
		logic [16:0]        sens;
		logic [12:0]        rng;
		logic [39:0]        env;
		logic [23:0]        gain;
		agc_result_t        pending[$];
		int                 errors;

		function void reset_state();
			att = ATT_RST;
			rel = REL_RST;
			tgt = TARGET_RST;
			sens = SENS_RST;
			rng = RANGE_RST;
			env = '0;
			gain = GAIN_ONE;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [24:0] val);
			case (idx)
				REG_ATTACK:  att = (val > COEFF_ONE) ? COEFF_ONE : val;
				REG_RELEASE: rel = (val > COEFF_ONE) ? COEFF_ONE : val;
				REG_TARGET:  tgt = val[14:0];
				REG_SENS:    sens = val[16:0];
				REG_RANGE:   rng = val[12:0];
				default: ;
			endcase
		endfunction

		// one-pole smoothing, shift taken on the magnitude of the step
		function logic [63:0] follow(logic [63:0] cur, logic [63:0] dst, logic [63:0] c);
			if (dst > cur)
				return cur + ((c * (dst - cur)) >> 24);
			return cur - ((c * (cur - dst)) >> 24);
		endfunction

		function logic [63:0] sqrt_floor(logic [63:0] v_in);
			logic [63:0] v, r, b;
			v = v_in;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// envelope to dB in q8.8 via log2 by repeated squaring
		function int level_db(logic [63:0] v);
			int          p;
			logic [63:0] m, fr, nl;
			p = 39;
			fr = 0;
			while (p > 0 && v[p] == 1'b0) p--;
			m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
			for (int k = 0; k < 16; k++) begin
				m = (m * m) >> 30;
				fr = fr << 1;
				if (m >= 64'd2147483648) begin
					fr[0] = 1'b1;
					m = m >> 1;
				end
			end
			nl = (64'(39 - p) << 16) - fr;
			return -int'((nl * 64'd394566 + (64'd1 << 23)) >> 24);
		endfunction

		// dB in q8.8 to linear gain in q4.20 through a sqrt chain
		function logic [63:0] db_gain(int db);
			logic [63:0] mg, fr, m, root, g;
			longint      e, biased;
			int          n, s;
			mg = (db < 0) ? 64'(-db) : 64'(db);
			e = longint'((mg * 64'd2786635 + 64'd32768) >> 16);
			if (db < 0) e = -e;
			biased = e + (longint'(64) << 16);
			if (biased < 0) biased = 0;
			n = int'(biased >> 16) - 64;
			fr = 64'(biased) & 64'hFFFF;
			m = 64'd1 << 30;
			root = 64'd2 << 30;
			for (int k = 1; k <= 16; k++) begin
				root = sqrt_floor(root << 30);
				if (fr[16 - k]) m = (m * root) >> 30;
			end
			s = 10 - n;
			if (s < 0) return 64'hFFFFFF;
			g = (s > 63) ? 0 : (m >> s);
			return (g > 64'hFFFFFF) ? 64'hFFFFFF : g;
		endfunction

		// accepted input sample: advance the state and queue the expected result
		function void note_sample(logic [23:0] raw);
			logic        neg;
			logic [63:0] mag, lvl, v, dm, sm, prod;
			int          db, d, scaled;
			agc_result_t r;
			neg = raw[23];
			mag = neg ? ((64'd1 << 24) - 64'(raw)) : 64'(raw);
			lvl = mag << (40 - SB);
			env = 40'(follow(64'(env), lvl, (lvl > 64'(env)) ? 64'(att) : 64'(rel)));
			v = (64'(env) < 64'(ENV_FLOOR)) ? 64'(ENV_FLOOR) : 64'(env);
			db = level_db(v);
			d = int'(tgt) - db;
			dm = (d < 0) ? 64'(-d) : 64'(d);
			sm = (dm * 64'(sens)) >> 16;
			if (sm > 64'(rng)) sm = 64'(rng);
			scaled = (d < 0) ? -int'(sm) : int'(sm);
			gain = 24'(follow(64'(gain), db_gain(scaled), 64'(att)));
			prod = (mag * 64'(gain) + (64'd1 << 19)) >> 20;
			if (neg) begin
				if (prod > 64'h800000) prod = 64'h800000;
				r.sample = 24'((64'd1 << 24) - prod);
			end else begin
				if (prod > 64'h7FFFFF) prod = 64'h7FFFFF;
				r.sample = prod[23:0];
			end
			r.gain = gain;
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(logic [47:0] data);
			agc_result_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, data);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (data[23:0] !== x.sample) begin
				$display("%0t: sample_out expected %h actual %h", $time, x.sample, data[23:0]);
				errors++;
			end
			if (data[47:24] !== x.gain) begin
				$display("%0t: gain_now expected %h actual %h", $time, x.gain, data[47:24]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [24:0] cfg_wdata = '0;

	agc_scoreboard sb = new();
	bit            calm;        // no idling on either side while set

	envelope_gain_rider_top #(.SAMPLE_BITS(SB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, checking on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= calm || ($urandom_range(99) >= 12);
		end
	end

	// register write while the block is idle, with write enable dropped again afterwards
	task automatic write_cfg(logic [2:0] idx, logic [24:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one input transfer, with a random gap first; tvalid stays up into the next item
	task automatic send_sample(logic [23:0] smp);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(smp);
	endtask

	// wait for every expected result, then a little beyond the latency
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// mostly small and mid-level audio, some full scale and silence
	function automatic logic [23:0] pick_sample();
		int sel;
		sel = $urandom_range(9);
		if (sel < 2) return 24'($urandom_range(255)) - 24'd128;
		if (sel < 6) return 24'($signed($urandom_range(65535)) - 32768) << $urandom_range(7);
		if (sel == 6) return ($urandom_range(1)) ? 24'h800000 : 24'h7FFFFF;
		return 24'($urandom);
	endfunction

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) send_sample(pick_sample());
	endtask

	initial begin
		static logic [23:0] directed[$] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h800001,
			24'hFFFFFF, 24'h000001, 24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000,
			24'h400000, 24'hC00000, 24'h7FFFFF, 24'h7FFFFF, 24'h000010, 24'hFFFFF0};
		sb.reset_state();
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, directed extremes and silence
		foreach (directed[i]) send_sample(directed[i]);
		drain();

		// fast attack, wide range, unknown register index ignored
		write_cfg(REG_ATTACK, COEFF_ONE);
		write_cfg(REG_RELEASE, 25'd16777215);
		write_cfg(REG_TARGET, 15'(-15360));
		write_cfg(REG_SENS, 17'd65536);
		write_cfg(REG_RANGE, 13'd6144);
		write_cfg(3'd5, 25'h1FFFFFF);
		write_cfg(3'd7, 25'd0);
		random_run(300);
		drain();

		// coefficients above one, registers at zero and beyond their range
		write_cfg(REG_ATTACK, 25'h1FFFFFF);
		write_cfg(REG_RELEASE, 25'd0);
		write_cfg(REG_TARGET, 15'd0);
		write_cfg(REG_SENS, 17'h1FFFF);
		write_cfg(REG_RANGE, 13'h1FFF);
		random_run(300);
		drain();

		write_cfg(REG_ATTACK, 25'd0);
		write_cfg(REG_RELEASE, COEFF_ONE);
		write_cfg(REG_TARGET, 15'h3FFF);
		write_cfg(REG_SENS, 17'd0);
		write_cfg(REG_RANGE, 13'd0);
		random_run(150);
		drain();

		// a long stretch without idling on either side
		calm = 1'b1;
		write_cfg(REG_ATTACK, 25'd400000);
		write_cfg(REG_RELEASE, 25'd20000);
		write_cfg(REG_TARGET, 15'(-4000));
		write_cfg(REG_SENS, 17'd32768);
		write_cfg(REG_RANGE, 13'd2000);
		random_run(300);
		calm = 1'b0;
		drain();

		// random register settings, a full drain before each new set of writes
		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(REG_ATTACK, 25'($urandom_range(16777216 + 200)));
			write_cfg(REG_RELEASE, 25'($urandom_range(2000000)));
			write_cfg(REG_TARGET, 15'(-$signed($urandom_range(15360))));
			write_cfg(REG_SENS, 17'($urandom_range(65536)));
			write_cfg(REG_RANGE, 13'($urandom_range(6144)));
			random_run(120);
			drain();
		end

		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog: about 2000 items plus gaps and stalls, taken well over
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/egr_pkg.sv
hdl/egr_mul.sv
hdl/egr_core.sv
hdl/envelope_gain_rider_top.sv
sim/tb_envelope_gain_rider_top.sv
